[sv/w2p_pkg.sv]
`default_nettype none
package w2p_pkg;

    // Input and output words of the stream channels.
    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic               clipped;
    } t_out_word;

    // Working value: every intermediate is held to +/-(2^62-1).
    localparam int VAL_W = 63;
    typedef logic signed [VAL_W-1:0] t_val;

    // Camera frame coordinate, 36 fractional bits, magnitude below 2^54.
    localparam int CAM_W = 56;
    typedef logic signed [CAM_W-1:0] t_cam;

    localparam t_val LIMV = 63'sh3FFF_FFFF_FFFF_FFFF;
    localparam t_val ONE_Q32 = 63'sh0000_0001_0000_0000;

    // Configuration register indexes.
    localparam logic [2:0] REG_FOCAL      = 3'd0;
    localparam logic [2:0] REG_PRINCIPAL  = 3'd1;
    localparam logic [2:0] REG_RADIAL     = 3'd2;
    localparam logic [2:0] REG_TANGENTIAL = 3'd3;
    localparam logic [2:0] REG_ROW_X      = 3'd4;
    localparam logic [2:0] REG_ROW_Y      = 3'd5;
    localparam logic [2:0] REG_ROW_Z      = 3'd6;
    localparam logic [2:0] REG_NONE       = 3'd7;

    localparam int MUL_LAT = 4;
    localparam int DIV_STEPS = 62;

    // Saturating add of two working values.
    function automatic t_val sadd(input t_val a, input t_val b);
        logic signed [VAL_W:0] s;
        t_val r;
        s = (VAL_W+1)'(a) + (VAL_W+1)'(b);
        if (s > (VAL_W+1)'(LIMV)) begin
            r = LIMV;
        end else if (s < -(VAL_W+1)'(LIMV)) begin
            r = -LIMV;
        end else begin
            r = s[VAL_W-1:0];
        end
        return r;
    endfunction

    // Sign extension of a 32-bit register half.
    function automatic t_val sx32(input logic [31:0] v);
        return t_val'($signed(v));
    endfunction

endpackage
`default_nettype wire

[sv/world_to_pixel_projection_top.sv]
`default_nettype none
// Projects points of the world plane (Z = 0, signed Q16.16) to integer pixel
// coordinates through a pinhole camera with Brown-Conrady radial and
// tangential distortion. The block takes one word in every clock cycle while
// the output is not stalled; its depth is set by the perspective divider,
// which produces one quotient bit per stage over 62 stages, followed by
// five pipelined 62 x 62 bit multiplier levels of four stages each. A stall
// on the output freezes the whole pipeline, so nothing is lost or repeated.
// Calibration and pose are written over the APB port at byte address
// 8 * index (64-bit data) and must only be changed while no word is in
// flight. Results are rounded half away from zero and saturated to 16 bits;
// clipped reports that either coordinate was saturated.
module world_to_pixel_projection_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  w2p_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  wire logic          i_stall,
    output w2p_pkg::t_out_word o_word,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [5:0]    paddr,
    input  wire logic [63:0]   pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import w2p_pkg::*;

    localparam int W2 = 2 * VAL_W;

    // The whole pipeline advances unless a finished word is held back.
    logic r_out_vld;
    logic pipe_en;
    assign pipe_en = !(r_out_vld && i_stall);
    assign o_stall = !pipe_en;

    // Configuration registers.
    logic [63:0] r_cfg [7];
    logic [2:0]  cfg_idx;
    assign cfg_idx = paddr[5:3];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 7; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (psel && penable && pwrite && cfg_idx != REG_NONE) begin
            r_cfg[cfg_idx] <= pwdata;
        end
    end

    assign prdata = (cfg_idx == REG_NONE) ? 64'd0 : r_cfg[cfg_idx];

    t_val fx, fy, cx, cy, k1, k2, p1, p2;
    always_comb begin
        fx = sx32(r_cfg[REG_FOCAL][31:0]);
        fy = sx32(r_cfg[REG_FOCAL][63:32]);
        cx = sx32(r_cfg[REG_PRINCIPAL][31:0]);
        cy = sx32(r_cfg[REG_PRINCIPAL][63:32]);
        k1 = sx32(r_cfg[REG_RADIAL][31:0]);
        k2 = sx32(r_cfg[REG_RADIAL][63:32]);
        p1 = sx32(r_cfg[REG_TANGENTIAL][31:0]);
        p2 = sx32(r_cfg[REG_TANGENTIAL][63:32]);
    end

    // Input register, then the rotation products, then the camera sums.
    logic               r_s0_vld, r_s1_vld, r_s2_vld;
    logic signed [31:0] r_s0_wx, r_s0_wy;
    logic signed [53:0] r_s1_p [6];
    t_cam               r_s2_c [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (pipe_en) begin
            r_s0_vld <= i_valid;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s0_wx <= i_word.world_x;
            r_s0_wy <= i_word.world_y;
            for (int k = 0; k < 3; k++) begin
                r_s1_p[2*k]   <= 54'($signed(r_cfg[REG_ROW_X + 3'(k)][21:0])) * 54'(r_s0_wx);
                r_s1_p[2*k+1] <= 54'($signed(r_cfg[REG_ROW_X + 3'(k)][43:22])) * 54'(r_s0_wy);
                r_s2_c[k]     <= CAM_W'(r_s1_p[2*k]) + CAM_W'(r_s1_p[2*k+1])
                               + (CAM_W'($signed(r_cfg[REG_ROW_X + 3'(k)][63:44])) <<< 28);
            end
        end
    end

    // Perspective division, 32 fractional bits out.
    logic dv_vld;
    t_val xn, yn;

    w2p_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (r_s2_vld),
        .i_num_x (r_s2_c[0]),
        .i_num_y (r_s2_c[1]),
        .i_den   (r_s2_c[2]),
        .o_vld   (dv_vld),
        .o_qx    (xn),
        .o_qy    (yn)
    );

    // First multiplier level: squares and cross product.
    t_val        l1_a [5], l1_b [5], l1_p [5];
    logic        l1_vld;
    logic [W2-1:0] l1_side;
    assign l1_a = '{xn, yn, xn, xn, yn};
    assign l1_b = '{xn, yn, yn, xn, yn};

    w2p_mul #(
        .LANES (5),
        .SHS   ({7'd31, 7'd31, 7'd31, 7'd32, 7'd32}),
        .SW    (W2)
    ) u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (dv_vld),
        .i_a     (l1_a),
        .i_b     (l1_b),
        .i_side  ({xn, yn}),
        .o_vld   (l1_vld),
        .o_p     (l1_p),
        .o_side  (l1_side)
    );

    // Radius squared, then the tangential weights.
    logic r_a_vld, r_b_vld;
    t_val r_a_r2, r_a_a1, r_a_xx, r_a_yy;
    logic [W2-1:0] r_a_xy, r_b_xy;
    t_val r_b_r2, r_b_a1, r_b_a2, r_b_a3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (pipe_en) begin
            r_a_vld <= l1_vld;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_a_r2 <= sadd(l1_p[0], l1_p[1]);
            r_a_a1 <= l1_p[2];
            r_a_xx <= l1_p[3];
            r_a_yy <= l1_p[4];
            r_a_xy <= l1_side;
            r_b_r2 <= r_a_r2;
            r_b_a1 <= r_a_a1;
            r_b_a2 <= sadd(r_a_r2, r_a_xx);
            r_b_a3 <= sadd(r_a_r2, r_a_yy);
            r_b_xy <= r_a_xy;
        end
    end

    // Second level: r^4, k1 term and the four tangential products.
    t_val        l2_a [6], l2_b [6], l2_p [6];
    logic        l2_vld;
    logic [W2-1:0] l2_side;
    assign l2_a = '{r_b_r2, k1, p1, p2, p1, p2};
    assign l2_b = '{r_b_r2, r_b_r2, r_b_a1, r_b_a2, r_b_a3, r_b_a1};

    w2p_mul #(
        .LANES (6),
        .SHS   ({7'd28, 7'd28, 7'd28, 7'd28, 7'd28, 7'd32}),
        .SW    (W2)
    ) u_mul2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (r_b_vld),
        .i_a     (l2_a),
        .i_b     (l2_b),
        .i_side  (r_b_xy),
        .o_vld   (l2_vld),
        .o_p     (l2_p),
        .o_side  (l2_side)
    );

    // Partial radial factor; tangential terms ride along.
    logic r_c_vld;
    t_val r_c_cdp, r_c_r4;
    logic [6*VAL_W-1:0] r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (pipe_en) begin
            r_c_vld <= l2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_c_cdp  <= sadd(ONE_Q32, l2_p[1]);
            r_c_r4   <= l2_p[0];
            r_c_side <= {l2_side, l2_p[2], l2_p[3], l2_p[4], l2_p[5]};
        end
    end

    // Third level: k2 term.
    t_val        l3_a [1], l3_b [1], l3_p [1];
    logic        l3_vld;
    logic [7*VAL_W-1:0] l3_side;
    assign l3_a = '{k2};
    assign l3_b = '{r_c_r4};

    w2p_mul #(
        .LANES (1),
        .SHS   (7'd28),
        .SW    (7*VAL_W)
    ) u_mul3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (r_c_vld),
        .i_a     (l3_a),
        .i_b     (l3_b),
        .i_side  ({r_c_cdp, r_c_side}),
        .o_vld   (l3_vld),
        .o_p     (l3_p),
        .o_side  (l3_side)
    );

    // Side layout after the third level, most significant first:
    // partial factor, xn, yn, p1*a1, p2*a2, p1*a3, p2*a1.
    logic r_d_vld;
    t_val r_d_cd, r_d_xn, r_d_yn;
    logic [4*VAL_W-1:0] r_d_tan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (pipe_en) begin
            r_d_vld <= l3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_d_cd  <= sadd(l3_side[6*VAL_W +: VAL_W], l3_p[0]);
            r_d_xn  <= l3_side[5*VAL_W +: VAL_W];
            r_d_yn  <= l3_side[4*VAL_W +: VAL_W];
            r_d_tan <= l3_side[4*VAL_W-1:0];
        end
    end

    // Fourth level: radial scaling of the normalised point.
    t_val        l4_a [2], l4_b [2], l4_p [2];
    logic        l4_vld;
    logic [4*VAL_W-1:0] l4_side;
    assign l4_a = '{r_d_xn, r_d_yn};
    assign l4_b = '{r_d_cd, r_d_cd};

    w2p_mul #(
        .LANES (2),
        .SHS   ({7'd32, 7'd32}),
        .SW    (4*VAL_W)
    ) u_mul4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (r_d_vld),
        .i_a     (l4_a),
        .i_b     (l4_b),
        .i_side  (r_d_tan),
        .o_vld   (l4_vld),
        .o_p     (l4_p),
        .o_side  (l4_side)
    );

    // Tangential terms are added one at a time, as saturation is not associative.
    logic r_e_vld, r_f_vld;
    t_val r_e_xs, r_e_ys, r_e_p2a2, r_e_p2a1;
    t_val r_f_xd, r_f_yd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (pipe_en) begin
            r_e_vld <= l4_vld;
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_e_xs   <= sadd(l4_p[0], l4_side[3*VAL_W +: VAL_W]);
            r_e_ys   <= sadd(l4_p[1], l4_side[VAL_W +: VAL_W]);
            r_e_p2a2 <= l4_side[2*VAL_W +: VAL_W];
            r_e_p2a1 <= l4_side[VAL_W-1:0];
            r_f_xd   <= sadd(r_e_xs, r_e_p2a2);
            r_f_yd   <= sadd(r_e_ys, r_e_p2a1);
        end
    end

    // Fifth level: focal scaling; the principal point travels with the word.
    t_val        l5_a [2], l5_b [2], l5_p [2];
    logic        l5_vld;
    logic [W2-1:0] l5_side;
    assign l5_a = '{r_f_xd, r_f_yd};
    assign l5_b = '{fx, fy};

    w2p_mul #(
        .LANES (2),
        .SHS   ({7'd32, 7'd32}),
        .SW    (W2)
    ) u_mul5 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (r_f_vld),
        .i_a     (l5_a),
        .i_b     (l5_b),
        .i_side  ({cx, cy}),
        .o_vld   (l5_vld),
        .o_p     (l5_p),
        .o_side  (l5_side)
    );

    // Offset, rounding and saturation to 16 bits.
    logic        r_g_vld, r_h_vld;
    t_val        r_g_u, r_g_v;
    logic [46:0] r_h_ru, r_h_rv;
    logic        r_h_nu, r_h_nv;
    t_out_word   r_out;

    logic signed [VAL_W:0] ru_full, rv_full;
    logic [15:0]           px, py;
    logic                  clip_x, clip_y;
    logic [16:0]           mx, my;

    always_comb begin
        // Magnitude plus one half in a single add: 2^15 - u when u is negative.
        ru_full = r_g_u[VAL_W-1] ? (64'sd32768 - 64'(r_g_u)) : (64'(r_g_u) + 64'sd32768);
        rv_full = r_g_v[VAL_W-1] ? (64'sd32768 - 64'(r_g_v)) : (64'(r_g_v) + 64'sd32768);

        if (r_h_nu) begin
            clip_x = r_h_ru > 47'd32768;
            mx     = clip_x ? 17'd32768 : r_h_ru[16:0];
            px     = 16'(17'd0 - mx);
        end else begin
            clip_x = |r_h_ru[46:15];
            mx     = 17'(r_h_ru[14:0]);
            px     = clip_x ? 16'h7FFF : mx[15:0];
        end
        if (r_h_nv) begin
            clip_y = r_h_rv > 47'd32768;
            my     = clip_y ? 17'd32768 : r_h_rv[16:0];
            py     = 16'(17'd0 - my);
        end else begin
            clip_y = |r_h_rv[46:15];
            my     = 17'(r_h_rv[14:0]);
            py     = clip_y ? 16'h7FFF : my[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld   <= 1'b0;
            r_h_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (pipe_en) begin
            r_g_vld   <= l5_vld;
            r_h_vld   <= r_g_vld;
            r_out_vld <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_g_u         <= sadd(l5_p[0], l5_side[VAL_W +: VAL_W]);
            r_g_v         <= sadd(l5_p[1], l5_side[VAL_W-1:0]);
            r_h_ru        <= ru_full[62:16];
            r_h_rv        <= rv_full[62:16];
            r_h_nu        <= r_g_u[VAL_W-1];
            r_h_nv        <= r_g_v[VAL_W-1];
            r_out.pixel_x <= px;
            r_out.pixel_y <= py;
            r_out.clipped <= clip_x | clip_y;
        end
    end

    assign o_valid = r_out_vld;
    assign o_word  = r_out;

endmodule
`default_nettype wire

[sv/w2p_mul.sv]
`default_nettype none
module w2p_mul #(
    parameter int LANES = 1,
    parameter logic [7*LANES-1:0] SHS = '0,
    parameter int SW = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  w2p_pkg::t_val         i_a [LANES],
    input  w2p_pkg::t_val         i_b [LANES],
    input  wire logic [SW-1:0]    i_side,
    output logic                  o_vld,
    output w2p_pkg::t_val         o_p [LANES],
    output logic [SW-1:0]         o_side
);
    import w2p_pkg::*;

    // Four stages: magnitudes, partial products, sum, shift and saturate.
    logic          r_vld [MUL_LAT];
    logic [SW-1:0] r_side [MUL_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MUL_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < MUL_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < MUL_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[MUL_LAT-1];
    assign o_side = r_side[MUL_LAT-1];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        localparam int SH = int'(SHS[7*g +: 7]);

        logic [61:0]  r_ma, r_mb;
        logic         r_neg1, r_neg2, r_neg3;
        logic [61:0]  r_pp00, r_pp01, r_pp10, r_pp11;
        logic [123:0] r_prod;
        t_val         r_out;
        t_val         abs_a, abs_b;
        logic [123:0] mid;
        logic [123:0] shv;
        logic [61:0]  mag;
        t_val         mv;

        always_comb begin
            abs_a = i_a[g][VAL_W-1] ? -i_a[g] : i_a[g];
            abs_b = i_b[g][VAL_W-1] ? -i_b[g] : i_b[g];
            mid   = 124'(r_pp01) + 124'(r_pp10);
            shv   = r_prod >> SH;
            mag   = (|shv[123:62]) ? LIMV[61:0] : shv[61:0];
            mv    = t_val'({1'b0, mag});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ma   <= abs_a[61:0];
                r_mb   <= abs_b[61:0];
                r_neg1 <= i_a[g][VAL_W-1] ^ i_b[g][VAL_W-1];
                r_pp00 <= r_ma[30:0] * r_mb[30:0];
                r_pp01 <= r_ma[30:0] * r_mb[61:31];
                r_pp10 <= r_ma[61:31] * r_mb[30:0];
                r_pp11 <= r_ma[61:31] * r_mb[61:31];
                r_neg2 <= r_neg1;
                r_prod <= 124'(r_pp00) + (mid << 31) + (124'(r_pp11) << 62);
                r_neg3 <= r_neg2;
                r_out  <= r_neg3 ? -mv : mv;
            end
        end

        assign o_p[g] = r_out;
    end

endmodule
`default_nettype wire

[sv/w2p_div.sv]
`default_nettype none
module w2p_div (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire logic     i_vld,
    input  w2p_pkg::t_cam i_num_x,
    input  w2p_pkg::t_cam i_num_y,
    input  w2p_pkg::t_cam i_den,
    output logic          o_vld,
    output w2p_pkg::t_val o_qx,
    output w2p_pkg::t_val o_qy
);
    import w2p_pkg::*;

    localparam int MAG_W = CAM_W - 1;

    // Front stages: magnitudes, then the overflow test and first remainder.
    logic               r_a_vld;
    logic [MAG_W-1:0]   r_a_mx, r_a_my, r_a_ud;
    logic               r_a_nx, r_a_ny;

    logic               r_vld [DIV_STEPS+1];
    logic [MAG_W-1:0]   r_rem_x [DIV_STEPS+1];
    logic [MAG_W-1:0]   r_rem_y [DIV_STEPS+1];
    logic [61:0]        r_lo_x  [DIV_STEPS+1];
    logic [61:0]        r_lo_y  [DIV_STEPS+1];
    logic [61:0]        r_q_x   [DIV_STEPS+1];
    logic [61:0]        r_q_y   [DIV_STEPS+1];
    logic [MAG_W-1:0]   r_ud    [DIV_STEPS+1];
    logic [3:0]         r_flg   [DIV_STEPS+1];

    logic               r_o_vld;
    t_val               r_o_qx, r_o_qy;

    t_cam               abs_x, abs_y, abs_z;
    t_val               qvx, qvy;
    logic [3:0]         flg_end;

    always_comb begin
        abs_x   = i_num_x[CAM_W-1] ? -i_num_x : i_num_x;
        abs_y   = i_num_y[CAM_W-1] ? -i_num_y : i_num_y;
        abs_z   = i_den[CAM_W-1] ? -i_den : i_den;
        flg_end = r_flg[DIV_STEPS];
        qvx     = flg_end[3] ? LIMV : t_val'({1'b0, r_q_x[DIV_STEPS]});
        qvy     = flg_end[2] ? LIMV : t_val'({1'b0, r_q_y[DIV_STEPS]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_vld[0] <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_vld[0] <= r_a_vld;
            r_o_vld <= r_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mx <= abs_x[MAG_W-1:0];
            r_a_my <= abs_y[MAG_W-1:0];
            // A zero depth divides by one: the same as dividing by 2^36 here.
            r_a_ud <= (i_den == '0) ? (MAG_W'(1) << 36) : abs_z[MAG_W-1:0];
            r_a_nx <= i_num_x[CAM_W-1] ^ i_den[CAM_W-1];
            r_a_ny <= i_num_y[CAM_W-1] ^ i_den[CAM_W-1];

            r_rem_x[0] <= MAG_W'(r_a_mx[MAG_W-1:30]);
            r_rem_y[0] <= MAG_W'(r_a_my[MAG_W-1:30]);
            r_lo_x[0]  <= {r_a_mx[29:0], 32'b0};
            r_lo_y[0]  <= {r_a_my[29:0], 32'b0};
            r_q_x[0]   <= '0;
            r_q_y[0]   <= '0;
            r_ud[0]    <= r_a_ud;
            r_flg[0]   <= {({30'b0, r_a_mx} >= {r_a_ud, 30'b0}),
                           ({30'b0, r_a_my} >= {r_a_ud, 30'b0}),
                           r_a_nx, r_a_ny};

            r_o_qx <= flg_end[1] ? -qvx : qvx;
            r_o_qy <= flg_end[0] ? -qvy : qvy;
        end
    end

    // One quotient bit per stage for each lane.
    for (genvar g = 1; g <= DIV_STEPS; g++) begin : g_step
        logic [MAG_W:0] tx, ty;
        logic           gex, gey;
        logic [MAG_W:0] dx, dy;

        always_comb begin
            tx  = {r_rem_x[g-1], r_lo_x[g-1][61]};
            ty  = {r_rem_y[g-1], r_lo_y[g-1][61]};
            gex = tx >= {1'b0, r_ud[g-1]};
            gey = ty >= {1'b0, r_ud[g-1]};
            dx  = gex ? tx - {1'b0, r_ud[g-1]} : tx;
            dy  = gey ? ty - {1'b0, r_ud[g-1]} : ty;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= r_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_x[g] <= dx[MAG_W-1:0];
                r_rem_y[g] <= dy[MAG_W-1:0];
                r_lo_x[g]  <= {r_lo_x[g-1][60:0], 1'b0};
                r_lo_y[g]  <= {r_lo_y[g-1][60:0], 1'b0};
                r_q_x[g]   <= {r_q_x[g-1][60:0], gex};
                r_q_y[g]   <= {r_q_y[g-1][60:0], gey};
                r_ud[g]    <= r_ud[g-1];
                r_flg[g]   <= r_flg[g-1];
            end
        end
    end

    assign o_vld = r_o_vld;
    assign o_qx  = r_o_qx;
    assign o_qy  = r_o_qy;

endmodule
`default_nettype wire
